// ----- hdl/hbrp_pkg.sv -----
// ----------------------------------------------------------------------------
// hbrp_pkg
// Shared constants, types and the prefix table of the byte-range parser.
// ----------------------------------------------------------------------------
package hbrp_pkg;

  // Width of the decimal values and of the file size used in the arithmetic.
  localparam int VALUE_WIDTH = 64;
  // Widths of the fields at the ports.
  localparam int CH_W        = 8;
  localparam int FIELD_W     = 64;
  // Four spare bits catch any overflow of value * 10 + digit.
  localparam int PROD_W      = VALUE_WIDTH + 4;
  localparam int DIGIT_W     = 4;

  localparam int PREFIX_LEN   = 6;
  localparam int PREFIX_POS_W = $clog2(PREFIX_LEN + 1);

  // Parser phases.
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // Character codes.
  localparam logic [CH_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Parser state as it stands after the last byte of a header.
  typedef struct packed {
    logic                   empty;
    logic                   bad;
    logic                   in_second;
    logic                   first_present;
    logic                   second_present;
    logic [VALUE_WIDTH-1:0] first_number;
    logic [VALUE_WIDTH-1:0] second_number;
    logic [VALUE_WIDTH-1:0] fsize;
  } snap_t;

  // Expected character at each position of the "bytes=" prefix.
  function automatic logic [CH_W-1:0] prefix_char(input logic [PREFIX_POS_W-1:0] pos);
    logic [CH_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h79;  // y
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h73;  // s
      3'd5:    c = 8'h3D;  // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/hbrp_parse.sv -----
// ----------------------------------------------------------------------------
// hbrp_parse
// Input register and header parser: checks the prefix and separators and
// accumulates the two decimals, one byte per cycle unless a last item waits.
// ----------------------------------------------------------------------------
module hbrp_parse (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [hbrp_pkg::CH_W-1:0]           in_ch,
  input  logic                                in_has_char,
  input  logic                                in_last,
  input  logic [hbrp_pkg::FIELD_W-1:0]        in_fsize,
  output logic                                snap_valid,
  input  logic                                snap_ready,
  output hbrp_pkg::snap_t                     snap
);

  localparam int VW = hbrp_pkg::VALUE_WIDTH;

  // Input register.
  logic                          item_valid;
  logic [hbrp_pkg::CH_W-1:0]     item_ch;
  logic                          item_has_char;
  logic                          item_last;
  logic [hbrp_pkg::FIELD_W-1:0]  item_fsize;

  // Parser state.
  logic [hbrp_pkg::PREFIX_POS_W-1:0] prefix_pos, prefix_pos_next;
  logic [1:0]                        phase, phase_next;
  logic                              bad_flag, bad_flag_next;
  logic [VW-1:0]                     first_number, first_number_next;
  logic                              first_present, first_present_next;
  logic [VW-1:0]                     second_number, second_number_next;
  logic                              second_present, second_present_next;

  logic                              snap_free;
  logic                              fire;
  logic                              is_digit;
  logic [hbrp_pkg::DIGIT_W-1:0]      digit;
  logic [VW-1:0]                     acc_sel;
  logic [hbrp_pkg::PROD_W-1:0]       acc_ext;
  logic [hbrp_pkg::PROD_W-1:0]       prod;
  logic                              ovf;

  // A last item can only leave once the snapshot register is free.
  assign snap_free     = !snap_valid || snap_ready;
  assign fire          = item_valid && (!item_last || snap_free);
  assign s_axis_tready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_ch       <= in_ch;
      item_has_char <= in_has_char;
      item_last     <= in_last;
      item_fsize    <= in_fsize;
    end
  end

  // One shared multiply-by-ten accumulator for whichever number is open.
  assign is_digit = (item_ch >= hbrp_pkg::CH_ZERO) && (item_ch <= hbrp_pkg::CH_NINE);
  assign digit    = hbrp_pkg::DIGIT_W'(item_ch - hbrp_pkg::CH_ZERO);
  assign acc_sel  = (phase == hbrp_pkg::PH_FIRST) ? first_number : second_number;
  assign acc_ext  = hbrp_pkg::PROD_W'(acc_sel);
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + hbrp_pkg::PROD_W'(digit);
  assign ovf      = |prod[hbrp_pkg::PROD_W-1:VW];

  always_comb begin
    prefix_pos_next     = prefix_pos;
    phase_next          = phase;
    bad_flag_next       = bad_flag;
    first_number_next   = first_number;
    first_present_next  = first_present;
    second_number_next  = second_number;
    second_present_next = second_present;
    if (item_has_char && !bad_flag) begin
      if (item_ch == hbrp_pkg::CH_COMMA) begin
        bad_flag_next = 1'b1;
      end else if (phase == hbrp_pkg::PH_PREFIX) begin
        if (item_ch == hbrp_pkg::prefix_char(prefix_pos)) begin
          prefix_pos_next = hbrp_pkg::PREFIX_POS_W'(prefix_pos + 1'b1);
          if (prefix_pos == hbrp_pkg::PREFIX_POS_W'(hbrp_pkg::PREFIX_LEN - 1)) begin
            phase_next = hbrp_pkg::PH_FIRST;
          end
        end else begin
          bad_flag_next = 1'b1;
        end
      end else if (item_ch == hbrp_pkg::CH_DASH) begin
        if (phase == hbrp_pkg::PH_FIRST) begin
          phase_next = hbrp_pkg::PH_SECOND;
        end else begin
          bad_flag_next = 1'b1;
        end
      end else if (!is_digit || ovf) begin
        bad_flag_next = 1'b1;
      end else if (phase == hbrp_pkg::PH_FIRST) begin
        first_number_next  = prod[VW-1:0];
        first_present_next = 1'b1;
      end else begin
        second_number_next  = prod[VW-1:0];
        second_present_next = 1'b1;
      end
    end
  end

  // The state returns to its reset values after every last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos     <= '0;
      phase          <= hbrp_pkg::PH_PREFIX;
      bad_flag       <= 1'b0;
      first_number   <= '0;
      first_present  <= 1'b0;
      second_number  <= '0;
      second_present <= 1'b0;
    end else if (fire) begin
      if (item_last) begin
        prefix_pos     <= '0;
        phase          <= hbrp_pkg::PH_PREFIX;
        bad_flag       <= 1'b0;
        first_number   <= '0;
        first_present  <= 1'b0;
        second_number  <= '0;
        second_present <= 1'b0;
      end else begin
        prefix_pos     <= prefix_pos_next;
        phase          <= phase_next;
        bad_flag       <= bad_flag_next;
        first_number   <= first_number_next;
        first_present  <= first_present_next;
        second_number  <= second_number_next;
        second_present <= second_present_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (fire && item_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item_last) begin
      snap.empty          <= (prefix_pos_next == '0) && (phase_next == hbrp_pkg::PH_PREFIX)
                             && !bad_flag_next;
      snap.bad            <= bad_flag_next;
      snap.in_second      <= (phase_next == hbrp_pkg::PH_SECOND);
      snap.first_present  <= first_present_next;
      snap.second_present <= second_present_next;
      snap.first_number   <= first_number_next;
      snap.second_number  <= second_number_next;
      snap.fsize          <= item_fsize[VW-1:0];
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && item_last) |=> (phase == hbrp_pkg::PH_PREFIX && prefix_pos == '0 && !bad_flag
                             && !first_present && !second_present))
    else $error("parser state not cleared after the last item");

  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == hbrp_pkg::PH_PREFIX) |-> (prefix_pos < hbrp_pkg::PREFIX_POS_W'(hbrp_pkg::PREFIX_LEN)))
    else $error("prefix position ran past the prefix");

endmodule

// ----- hdl/hbrp_range.sv -----
// ----------------------------------------------------------------------------
// hbrp_range
// Range check: turns the parsed header and file size into first byte, length
// and flags, held in the output register.
// ----------------------------------------------------------------------------
module hbrp_range (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          snap_valid,
  output logic                          snap_ready,
  input  hbrp_pkg::snap_t               snap,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic                          range_ok,
  output logic [hbrp_pkg::FIELD_W-1:0]  first_byte,
  output logic [hbrp_pkg::FIELD_W-1:0]  byte_count,
  output logic                          is_partial
);

  localparam int VW = hbrp_pkg::VALUE_WIDTH;

  logic          out_move;
  logic          fs_zero;
  logic          second_lt_fs;
  logic          first_lt_fs;
  logic          second_ge_first;
  logic [VW-1:0] fs_minus_second;
  logic [VW-1:0] fs_minus_first;
  logic [VW-1:0] closed_count;
  logic          ok;
  logic [VW-1:0] start;
  logic [VW-1:0] count;

  assign out_move   = !m_axis_tvalid || m_axis_tready;
  assign snap_ready = out_move;

  // All compares and differences run side by side; the form picks one.
  assign fs_zero         = (snap.fsize == '0);
  assign second_lt_fs    = (snap.second_number < snap.fsize);
  assign first_lt_fs     = (snap.first_number < snap.fsize);
  assign second_ge_first = (snap.second_number >= snap.first_number);
  assign fs_minus_second = snap.fsize - snap.second_number;
  assign fs_minus_first  = snap.fsize - snap.first_number;
  assign closed_count    = snap.second_number - snap.first_number + 1'b1;

  always_comb begin
    ok    = 1'b0;
    start = '0;
    count = '0;
    if (fs_zero) begin
      ok = 1'b0;
    end else if (snap.empty) begin
      ok    = 1'b1;
      count = snap.fsize;
    end else if (snap.bad || !snap.in_second) begin
      ok = 1'b0;
    end else if (!snap.first_present) begin
      // Suffix form: the last N bytes, clipped to the whole file.
      if (snap.second_present && snap.second_number != '0) begin
        ok    = 1'b1;
        start = second_lt_fs ? fs_minus_second : '0;
        count = second_lt_fs ? snap.second_number : snap.fsize;
      end
    end else if (first_lt_fs) begin
      if (!snap.second_present) begin
        ok    = 1'b1;
        start = snap.first_number;
        count = fs_minus_first;
      end else if (second_ge_first && second_lt_fs) begin
        ok    = 1'b1;
        start = snap.first_number;
        count = closed_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_move) begin
      m_axis_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && snap_valid) begin
      range_ok   <= ok;
      first_byte <= hbrp_pkg::FIELD_W'(start);
      byte_count <= hbrp_pkg::FIELD_W'(count);
      is_partial <= ok && !snap.empty;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !range_ok) |-> (first_byte == '0 && byte_count == '0 && !is_partial))
    else $error("invalid result carries nonzero fields");

  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && range_ok) |-> (byte_count != '0))
    else $error("valid range with zero length");

endmodule

// ----- hdl/http_byte_range_parser_unit.sv -----
// ----------------------------------------------------------------------------
// http_byte_range_parser_unit
// Parses a single-range HTTP Range header, one byte per item, and reports the
// selected byte range within a file.
// ----------------------------------------------------------------------------
//
//   channel  | direction | tdata                           | tuser / tlast
//   s_axis   | in        | [7:0] ch, [71:8] fsize          | tuser[0] has_char, tlast last
//   m_axis   | out       | [63:0] first_byte,              | tuser[0] range_ok,
//            |           | [127:64] byte_count             | tuser[1] is_partial
//
// One item is accepted per cycle unless a last item waits for a full snapshot
// register. A result passes the input register, the parse state / snapshot
// register and the output register after its last item is accepted. The
// per-byte loop is a single multiply-by-ten accumulate.
// Reset (rst, synchronous) clears the parser state and all valid flags.
// When m_axis stalls, the output register and the snapshot register hold;
// items without last keep flowing until a last item finds both of them full.
// ----------------------------------------------------------------------------
module http_byte_range_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // [7:0] ch, [71:8] fsize
  input  logic [0:0]   s_axis_tuser,   // [0] has_char
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] first_byte, [127:64] byte_count
  output logic [1:0]   m_axis_tuser    // [0] range_ok, [1] is_partial
);

  logic                                snap_valid;
  logic                                snap_ready;
  hbrp_pkg::snap_t                     snap;
  logic                                range_ok;
  logic [hbrp_pkg::FIELD_W-1:0]        first_byte;
  logic [hbrp_pkg::FIELD_W-1:0]        byte_count;
  logic                                is_partial;

  hbrp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .in_ch         (s_axis_tdata[7:0]),
    .in_has_char   (s_axis_tuser[0]),
    .in_last       (s_axis_tlast),
    .in_fsize      (s_axis_tdata[71:8]),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap          (snap)
  );

  hbrp_range u_range (
    .clk           (clk),
    .rst           (rst),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap          (snap),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .range_ok      (range_ok),
    .first_byte    (first_byte),
    .byte_count    (byte_count),
    .is_partial    (is_partial)
  );

  assign m_axis_tdata = {byte_count, first_byte};
  assign m_axis_tuser = {is_partial, range_ok};

endmodule
